// File: sv/source_text_tokenizer_assert.svh
// assertion macros for the source text tokenizer
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define STT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/stt_pkg.sv
// shared types and constants for the source text tokenizer
// no dependencies
`timescale 1ns / 1ps
package stt_pkg;
  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_NUMBER = 6'd1;
  localparam logic [5:0] K_MINUS = 6'd2;
  localparam logic [5:0] K_PLUS = 6'd3;
  localparam logic [5:0] K_TIMES = 6'd4;
  localparam logic [5:0] K_DIVIDE = 6'd5;
  localparam logic [5:0] K_MODULO = 6'd6;
  localparam logic [5:0] K_AND = 6'd7;
  localparam logic [5:0] K_OR = 6'd8;
  localparam logic [5:0] K_XOR = 6'd9;
  localparam logic [5:0] K_EQ = 6'd10;
  localparam logic [5:0] K_EQEQ = 6'd11;
  localparam logic [5:0] K_NE = 6'd12;
  localparam logic [5:0] K_LT = 6'd13;
  localparam logic [5:0] K_LE = 6'd14;
  localparam logic [5:0] K_SHL = 6'd15;
  localparam logic [5:0] K_GT = 6'd16;
  localparam logic [5:0] K_GE = 6'd17;
  localparam logic [5:0] K_SHR = 6'd18;
  localparam logic [5:0] K_SEMI = 6'd19;
  localparam logic [5:0] K_LPAREN = 6'd20;
  localparam logic [5:0] K_RPAREN = 6'd21;
  localparam logic [5:0] K_LBRACE = 6'd22;
  localparam logic [5:0] K_RBRACE = 6'd23;
  localparam logic [5:0] K_COMMA = 6'd24;
  localparam logic [5:0] K_COLON = 6'd25;
  localparam logic [5:0] K_QUOTE = 6'd26;
  localparam logic [5:0] K_IDENT = 6'd27;
  localparam logic [5:0] K_CST = 6'd28;
  localparam logic [5:0] K_NAME = 6'd34;
  localparam logic [5:0] K_ERROR = 6'd35;
  localparam logic [5:0] PREV_NONE = 6'd63;
  localparam int MAX_RES = 6;

  // keyword spelling, five bytes each, zero padded
  localparam logic [7:0] KW_TEXT [6][5] = '{
    '{8'h63, 8'h73, 8'h74, 8'h00, 8'h00},
    '{8'h76, 8'h61, 8'h72, 8'h00, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65},
    '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00},
    '{8'h69, 8'h36, 8'h34, 8'h00, 8'h00}};
  localparam logic [2:0] KW_LEN [6] = '{3'd3, 3'd3, 3'd2, 3'd5, 3'd4, 3'd3};

  // one result as it leaves the block
  typedef struct packed {
    logic [5:0]  kind;
    logic [63:0] value;
    logic [7:0]  byte_v;
  } res_t;

  // one decoded action: up to six results plus a count and the line
  typedef struct packed {
    logic [2:0] cnt;
    res_t [MAX_RES-1:0] res;
    logic [31:0] line;
  } batch_t;
endpackage

// File: sv/stt_front.sv
// front end: scanner state machine, turns one byte into a batch of results
// depends on stt_pkg
`timescale 1ns / 1ps
module stt_front #(
  parameter int LINE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_kind,
  input  logic [7:0] in_byte,
  output logic b_valid,
  input  logic b_ready,
  output stt_pkg::batch_t b_data
);
  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_COMMENT = 16'h0002, S_BLOCK0 = 16'h0004,
    S_BLOCK1 = 16'h0008, S_BLOCK2 = 16'h0010, S_QUOTE1 = 16'h0020,
    S_QUOTE2 = 16'h0040, S_STRING = 16'h0080, S_WORD = 16'h0100,
    S_NUMBER = 16'h0200, S_MINUS = 16'h0400, S_SLASH = 16'h0800,
    S_BANG = 16'h1000, S_EQ = 16'h2000, S_LT = 16'h4000, S_GT = 16'h8000
  } state_t;

  localparam logic [63:0] POS_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_CAP = 64'h8000_0000_0000_0000;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  state_t state, state_next;
  logic [63:0] accum, accum_next;
  logic neg, neg_next;
  logic [5:0] kwm, kwm_next;
  logic [2:0] wlen, wlen_next;
  logic [5:0] prev, prev_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic halted, halted_next;
  stt_pkg::batch_t bat;
  logic [LINE_BITS-1:0] eline;
  logic [63:0] acc10;
  logic [63:0] dig;
  logic [63:0] lim;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  // append one result to the batch for this item
  task automatic push(inout stt_pkg::batch_t b, input logic [5:0] k,
                      input logic [63:0] v, input logic [7:0] by, inout logic [5:0] pk);
    b.res[b.cnt] = '{kind: k, value: v, byte_v: by};
    b.cnt = b.cnt + 3'd1;
    if (k != stt_pkg::K_NAME && k != stt_pkg::K_ERROR) pk = k;
  endtask

  assign in_ready = !b_valid || b_ready;
  assign acc10 = (accum << 3) + (accum << 1);
  assign dig = {60'd0, in_byte[3:0]};
  // saturation cap for the sign; the digit step compares accum*10 with cap - d
  assign lim = neg ? NEG_CAP : POS_CAP;

  always_comb begin
    logic [5:0] kword;
    logic go_idle;
    logic [63:0] nv;
    state_next = state;
    accum_next = accum;
    neg_next = neg;
    kwm_next = kwm;
    wlen_next = wlen;
    prev_next = prev;
    line_next = line;
    halted_next = halted;
    bat = '0;
    bat.line = 32'(eline);
    go_idle = 1'b0;
    kword = stt_pkg::K_IDENT;
    nv = neg ? (64'd0 - accum) : accum;
    for (int k = 0; k < 6; k++)
      if (kwm[k] && wlen == stt_pkg::KW_LEN[k]) kword = stt_pkg::K_CST + 6'(k);
    if (!halted) begin
      if (in_kind) begin
        // end of text
        unique case (state)
          S_WORD: push(bat, kword, '0, '0, prev_next);
          S_NUMBER: push(bat, stt_pkg::K_NUMBER, nv, '0, prev_next);
          S_MINUS: push(bat, stt_pkg::K_MINUS, '0, '0, prev_next);
          S_EQ: push(bat, stt_pkg::K_EQ, '0, '0, prev_next);
          S_LT: push(bat, stt_pkg::K_LT, '0, '0, prev_next);
          S_GT: push(bat, stt_pkg::K_GT, '0, '0, prev_next);
          S_QUOTE2: begin
            push(bat, stt_pkg::K_QUOTE, '0, '0, prev_next);
            push(bat, stt_pkg::K_IDENT, '0, '0, prev_next);
            push(bat, stt_pkg::K_QUOTE, '0, '0, prev_next);
          end
          default: ;
        endcase
        if (state == S_SLASH || state == S_BANG || state == S_QUOTE1 || state == S_STRING) begin
          push(bat, stt_pkg::K_ERROR, '0,
               state == S_SLASH ? 8'h2f : (state == S_BANG ? 8'h21 : 8'h00), prev_next);
          halted_next = 1'b1;
        end else begin
          push(bat, stt_pkg::K_EOF, '0, '0, prev_next);
          state_next = S_IDLE;
          accum_next = '0;
          neg_next = 1'b0;
          kwm_next = '1;
          wlen_next = '0;
          prev_next = stt_pkg::PREV_NONE;
          line_next = LINE_BITS'(1);
        end
      end else begin
        unique case (state)
          S_IDLE: go_idle = 1'b1;
          S_COMMENT: go_idle = in_byte == 8'h0a;
          S_BLOCK0, S_BLOCK1, S_BLOCK2: begin
            if (in_byte == 8'h22) begin
              state_next = state == S_BLOCK0 ? S_BLOCK1 : (state == S_BLOCK1 ? S_BLOCK2 : S_IDLE);
            end else begin
              if (in_byte == 8'h0a && line != LINE_MAX) line_next = line + 1'b1;
              state_next = S_BLOCK0;
            end
          end
          S_QUOTE1: begin
            if (in_byte == 8'h22) state_next = S_QUOTE2;
            else begin
              push(bat, stt_pkg::K_QUOTE, '0, '0, prev_next);
              push(bat, stt_pkg::K_NAME, '0, in_byte, prev_next);
              state_next = S_STRING;
            end
          end
          S_QUOTE2: begin
            if (in_byte == 8'h22) state_next = S_BLOCK0;
            else begin
              push(bat, stt_pkg::K_QUOTE, '0, '0, prev_next);
              push(bat, stt_pkg::K_IDENT, '0, '0, prev_next);
              push(bat, stt_pkg::K_QUOTE, '0, '0, prev_next);
              go_idle = 1'b1;
            end
          end
          S_STRING: begin
            if (in_byte == 8'h22) begin
              push(bat, stt_pkg::K_IDENT, '0, '0, prev_next);
              push(bat, stt_pkg::K_QUOTE, '0, '0, prev_next);
              state_next = S_IDLE;
            end else push(bat, stt_pkg::K_NAME, '0, in_byte, prev_next);
          end
          S_WORD: begin
            if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == 8'h5f) begin
              for (int k = 0; k < 6; k++)
                if (wlen >= stt_pkg::KW_LEN[k] ||
                    stt_pkg::KW_TEXT[k][wlen[2:0] > 3'd4 ? 3'd4 : wlen] != in_byte)
                  kwm_next[k] = 1'b0;
              if (wlen != 3'd7) wlen_next = wlen + 3'd1;
              push(bat, stt_pkg::K_NAME, '0, in_byte, prev_next);
            end else begin
              push(bat, kword, '0, '0, prev_next);
              go_idle = 1'b1;
            end
          end
          S_NUMBER: begin
            if (is_digit(in_byte)) begin
              // saturate when accum*10 + d would pass the cap
              if (accum > 64'h0CCC_CCCC_CCCC_CCCC || acc10 > lim - dig) accum_next = lim;
              else accum_next = acc10 + dig;
            end else begin
              push(bat, stt_pkg::K_NUMBER, nv, '0, prev_next);
              go_idle = 1'b1;
            end
          end
          S_MINUS: begin
            if (is_digit(in_byte)) begin
              neg_next = 1'b1;
              accum_next = dig;
              state_next = S_NUMBER;
            end else begin
              push(bat, stt_pkg::K_MINUS, '0, '0, prev_next);
              go_idle = 1'b1;
            end
          end
          S_SLASH: begin
            if (in_byte == 8'h2f) begin
              push(bat, stt_pkg::K_DIVIDE, '0, '0, prev_next);
              state_next = S_IDLE;
            end else begin
              push(bat, stt_pkg::K_ERROR, '0, 8'h2f, prev_next);
              halted_next = 1'b1;
            end
          end
          S_BANG: begin
            if (in_byte == 8'h3d) begin
              push(bat, stt_pkg::K_NE, '0, '0, prev_next);
              state_next = S_IDLE;
            end else begin
              push(bat, stt_pkg::K_ERROR, '0, 8'h21, prev_next);
              halted_next = 1'b1;
            end
          end
          S_EQ: begin
            if (in_byte == 8'h3d) begin
              push(bat, stt_pkg::K_EQEQ, '0, '0, prev_next);
              state_next = S_IDLE;
            end else begin
              push(bat, stt_pkg::K_EQ, '0, '0, prev_next);
              go_idle = 1'b1;
            end
          end
          S_LT, S_GT: begin
            if (in_byte == 8'h3d) begin
              push(bat, state == S_LT ? stt_pkg::K_LE : stt_pkg::K_GE, '0, '0, prev_next);
              state_next = S_IDLE;
            end else if ((state == S_LT && in_byte == 8'h3c) ||
                         (state == S_GT && in_byte == 8'h3e)) begin
              push(bat, state == S_LT ? stt_pkg::K_SHL : stt_pkg::K_SHR, '0, '0, prev_next);
              state_next = S_IDLE;
            end else begin
              push(bat, state == S_LT ? stt_pkg::K_LT : stt_pkg::K_GT, '0, '0, prev_next);
              go_idle = 1'b1;
            end
          end
          default: ;
        endcase
        // byte scanned from idle
        if (go_idle) begin
          state_next = S_IDLE;
          case (in_byte)
            8'h23: state_next = S_COMMENT;
            8'h22: state_next = S_QUOTE1;
            8'h0a: begin
              if (prev_next != stt_pkg::PREV_NONE && prev_next != stt_pkg::K_LBRACE &&
                  prev_next != stt_pkg::K_RBRACE && prev_next != stt_pkg::K_SEMI)
                push(bat, stt_pkg::K_SEMI, '0, '0, prev_next);
              if (line != LINE_MAX) line_next = line + 1'b1;
            end
            8'h2d: state_next = S_MINUS;
            8'h2f: state_next = S_SLASH;
            8'h21: state_next = S_BANG;
            8'h3d: state_next = S_EQ;
            8'h3c: state_next = S_LT;
            8'h3e: state_next = S_GT;
            8'h2b: push(bat, stt_pkg::K_PLUS, '0, '0, prev_next);
            8'h2a: push(bat, stt_pkg::K_TIMES, '0, '0, prev_next);
            8'h25: push(bat, stt_pkg::K_MODULO, '0, '0, prev_next);
            8'h26: push(bat, stt_pkg::K_AND, '0, '0, prev_next);
            8'h7c: push(bat, stt_pkg::K_OR, '0, '0, prev_next);
            8'h5e: push(bat, stt_pkg::K_XOR, '0, '0, prev_next);
            8'h3b: push(bat, stt_pkg::K_SEMI, '0, '0, prev_next);
            8'h28: push(bat, stt_pkg::K_LPAREN, '0, '0, prev_next);
            8'h29: push(bat, stt_pkg::K_RPAREN, '0, '0, prev_next);
            8'h7b: push(bat, stt_pkg::K_LBRACE, '0, '0, prev_next);
            8'h7d: push(bat, stt_pkg::K_RBRACE, '0, '0, prev_next);
            8'h2c: push(bat, stt_pkg::K_COMMA, '0, '0, prev_next);
            8'h3a: push(bat, stt_pkg::K_COLON, '0, '0, prev_next);
            8'h20, 8'h09: ;
            default: begin
              if (is_digit(in_byte)) begin
                state_next = S_NUMBER;
                neg_next = 1'b0;
                accum_next = dig;
              end else if (is_alpha(in_byte)) begin
                state_next = S_WORD;
                wlen_next = 3'd1;
                for (int k = 0; k < 6; k++)
                  kwm_next[k] = stt_pkg::KW_TEXT[k][0] == in_byte;
                push(bat, stt_pkg::K_NAME, '0, in_byte, prev_next);
              end else begin
                push(bat, stt_pkg::K_ERROR, '0, in_byte, prev_next);
                halted_next = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  // results carry the line as it stood before this item; only newline
  // and block comments move it, and neither emits after moving
  assign eline = line;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      accum <= '0;
      neg <= 1'b0;
      kwm <= '1;
      wlen <= '0;
      prev <= stt_pkg::PREV_NONE;
      line <= LINE_BITS'(1);
      halted <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        state <= state_next;
        accum <= accum_next;
        neg <= neg_next;
        kwm <= kwm_next;
        wlen <= wlen_next;
        prev <= prev_next;
        line <= line_next;
        halted <= halted_next;
        b_valid <= bat.cnt != 3'd0;
      end else if (b_ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b_data <= bat;
    end
  end
endmodule

// File: sv/stt_back.sv
// back end: queue of result batches and serialiser onto the output port
// depends on stt_pkg
`timescale 1ns / 1ps
module stt_back (
  input  logic clk,
  input  logic rst,
  input  logic b_valid,
  output logic b_ready,
  input  stt_pkg::batch_t b_data,
  output logic out_valid,
  input  logic out_ready,
  output stt_pkg::res_t out_res,
  output logic [31:0] out_line,
  output logic out_last
);
  localparam int DEPTH = 4;
  stt_pkg::batch_t mem [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic [2:0] idx;
  stt_pkg::batch_t head;
  logic pop;

  assign b_ready = count != 3'(DEPTH);
  assign head = mem[rd_ptr];
  assign out_valid = count != 3'd0;
  assign out_res = head.res[idx];
  assign out_line = head.line;
  assign out_last = idx + 3'd1 == head.cnt;
  assign pop = out_valid && out_ready && out_last;

  // batch storage
  always_ff @(posedge clk) begin
    if (b_valid && b_ready) mem[wr_ptr] <= b_data;
  end

  // pointers and result index within the head batch
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      idx <= '0;
    end else begin
      if (b_valid && b_ready) wr_ptr <= wr_ptr + 2'd1;
      if (out_valid && out_ready) idx <= out_last ? 3'd0 : idx + 3'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(b_valid && b_ready) - 3'(pop);
    end
  end
endmodule

// File: sv/source_text_tokenizer.sv
// top level of the source text tokenizer
// depends on stt_pkg, stt_front, stt_back and source_text_tokenizer_assert.svh
`timescale 1ns / 1ps
// Takes one source byte (or an end-of-text item) per transfer, one item a
// cycle, and streams out typed tokens tagged with their line. The scanner
// handles each item, registers its batch of up to four results and hands
// it to a four-entry queue; the output side sends one result per cycle
// while the receiver is ready, and input stalls only when the queue is
// full. After an error result the block ignores all input until reset.
`include "source_text_tokenizer_assert.svh"
module source_text_tokenizer #(
  parameter int LINE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic valid_in,
  output logic ready_in,
  input  logic kind,
  input  logic [7:0] char_byte,
  output logic valid_out,
  input  logic ready_out,
  output logic [5:0] token_kind,
  output logic [LINE_BITS-1:0] src_line,
  output logic signed [63:0] number_value,
  output logic [7:0] name_byte,
  output logic last
);
  logic b_valid, b_ready;
  stt_pkg::batch_t b_data;
  stt_pkg::res_t res;
  logic [31:0] line_w;

  stt_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(valid_in), .in_ready(ready_in),
    .in_kind(kind), .in_byte(char_byte),
    .b_valid(b_valid), .b_ready(b_ready), .b_data(b_data));

  stt_back u_back (
    .clk(clk), .rst(rst), .b_valid(b_valid), .b_ready(b_ready), .b_data(b_data),
    .out_valid(valid_out), .out_ready(ready_out), .out_res(res),
    .out_line(line_w), .out_last(last));

  assign token_kind = res.kind;
  assign number_value = res.value;
  assign name_byte = res.byte_v;
  assign src_line = line_w[LINE_BITS-1:0];

  `STT_ASSERT_IMPL(a_line_nonzero, clk, rst, valid_out, src_line != '0, "line is zero")
  `STT_ASSERT_IMPL(a_kind_range, clk, rst, valid_out, token_kind <= stt_pkg::K_ERROR,
    "bad token kind")
  `STT_ASSERT_NEXT(a_err_last, clk, rst, valid_out && ready_out && token_kind == stt_pkg::K_ERROR,
    !valid_out, "result after error")
endmodule

// File: verif/tb_source_text_tokenizer.sv
// self-checking testbench for the source text tokenizer
// depends on stt_pkg and source_text_tokenizer; drives byte streams, predicts tokens
`timescale 1ns / 1ps
module tb_source_text_tokenizer;

  typedef enum int {
    SC_IDLE, SC_COMMENT, SC_BLOCK0, SC_BLOCK1, SC_BLOCK2, SC_QUOTE1, SC_QUOTE2,
    SC_STRING, SC_WORD, SC_NUMBER, SC_MINUS, SC_SLASH, SC_BANG, SC_EQ, SC_LT, SC_GT
  } scan_e;

  typedef struct {
    logic [5:0]  tok;
    logic [23:0] line;
    logic [63:0] value;
    logic [7:0]  nbyte;
    logic        fin;
  } token_t;

  // token predictor and store of expected tokens
  class token_scoreboard;
    scan_e       mode;
    logic [63:0] accum;
    logic        neg;
    logic [5:0]  kw_live;
    int          wlen;
    logic [5:0]  prev;
    logic [23:0] line_ctr;
    logic        halted;
    token_t      expected_q[$];
    int          made;
    int          mismatches;

    function void clear();
      mode = SC_IDLE;
      accum = '0;
      neg = 1'b0;
      kw_live = 6'h3f;
      wlen = 0;
      prev = stt_pkg::PREV_NONE;
      line_ctr = 24'd1;
      halted = 1'b0;
    endfunction

    function void push_tok(logic [5:0] t, logic [63:0] v, logic [7:0] b);
      token_t e;
      if (made >= stt_pkg::MAX_RES) return;
      e.tok = t; e.line = line_ctr; e.value = v; e.nbyte = b; e.fin = 1'b0;
      expected_q.insert(expected_q.size(), e);
      made++;
      if (t != stt_pkg::K_NAME && t != stt_pkg::K_ERROR) prev = t;
    endfunction

    function void raise_error(logic [7:0] b);
      push_tok(stt_pkg::K_ERROR, '0, b);
      halted = 1'b1;
    endfunction

    function void add_word_char(logic [7:0] c);
      for (int k = 0; k < 6; k++)
        if (kw_live[k] && (wlen >= stt_pkg::KW_LEN[k] || stt_pkg::KW_TEXT[k][wlen] != c))
          kw_live[k] = 1'b0;
      if (wlen < 7) wlen++;
      push_tok(stt_pkg::K_NAME, '0, c);
    endfunction

    function void close_word();
      logic [5:0] t;
      t = stt_pkg::K_IDENT;
      for (int k = 0; k < 6; k++)
        if (kw_live[k] && wlen == stt_pkg::KW_LEN[k]) t = stt_pkg::K_CST + 6'(k);
      push_tok(t, '0, '0);
    endfunction

    function void close_number();
      push_tok(stt_pkg::K_NUMBER, neg ? 64'd0 - accum : accum, '0);
    endfunction

    function void bump_line();
      if (line_ctr != 24'hffffff) line_ctr++;
    endfunction

    function void quote_pair();
      push_tok(stt_pkg::K_QUOTE, '0, '0);
      push_tok(stt_pkg::K_IDENT, '0, '0);
      push_tok(stt_pkg::K_QUOTE, '0, '0);
    endfunction

    function void feed(logic [7:0] c);
      logic dig, alp;
      logic [63:0] cap, d;
      dig = c >= "0" && c <= "9";
      alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      // per-mode step; modes that do not return hand the byte on to the idle scan
      case (mode)
        SC_COMMENT: if (c != 8'h0a) return;
        SC_BLOCK0, SC_BLOCK1, SC_BLOCK2: begin
          if (c == "\"") begin
            mode = (mode == SC_BLOCK2) ? SC_IDLE : scan_e'(mode + 1);
          end else begin
            if (c == 8'h0a) bump_line();
            mode = SC_BLOCK0;
          end
          return;
        end
        SC_QUOTE1: begin
          if (c == "\"") begin mode = SC_QUOTE2; return; end
          push_tok(stt_pkg::K_QUOTE, '0, '0);
          push_tok(stt_pkg::K_NAME, '0, c);
          mode = SC_STRING;
          return;
        end
        SC_QUOTE2: begin
          if (c == "\"") begin mode = SC_BLOCK0; return; end
          quote_pair();
        end
        SC_STRING: begin
          if (c == "\"") begin
            push_tok(stt_pkg::K_IDENT, '0, '0);
            push_tok(stt_pkg::K_QUOTE, '0, '0);
            mode = SC_IDLE;
          end else begin
            push_tok(stt_pkg::K_NAME, '0, c);
          end
          return;
        end
        SC_WORD: begin
          if (alp || dig || c == "_") begin add_word_char(c); return; end
          close_word();
        end
        SC_NUMBER: begin
          if (dig) begin
            d = 64'(c - "0");
            cap = neg ? 64'h8000000000000000 : 64'h7fffffffffffffff;
            if (accum > (cap - d) / 10) accum = cap;
            else accum = accum * 10 + d;
            return;
          end
          close_number();
        end
        SC_MINUS: begin
          if (dig) begin
            neg = 1'b1; accum = 64'(c - "0"); mode = SC_NUMBER;
            return;
          end
          push_tok(stt_pkg::K_MINUS, '0, '0);
        end
        SC_SLASH: begin
          if (c == "/") begin push_tok(stt_pkg::K_DIVIDE, '0, '0); mode = SC_IDLE; end
          else raise_error("/");
          return;
        end
        SC_BANG: begin
          if (c == "=") begin push_tok(stt_pkg::K_NE, '0, '0); mode = SC_IDLE; end
          else raise_error("!");
          return;
        end
        SC_EQ: begin
          if (c == "=") begin push_tok(stt_pkg::K_EQEQ, '0, '0); mode = SC_IDLE; return; end
          push_tok(stt_pkg::K_EQ, '0, '0);
        end
        SC_LT: begin
          if (c == "=") begin push_tok(stt_pkg::K_LE, '0, '0); mode = SC_IDLE; return; end
          if (c == "<") begin push_tok(stt_pkg::K_SHL, '0, '0); mode = SC_IDLE; return; end
          push_tok(stt_pkg::K_LT, '0, '0);
        end
        SC_GT: begin
          if (c == "=") begin push_tok(stt_pkg::K_GE, '0, '0); mode = SC_IDLE; return; end
          if (c == ">") begin push_tok(stt_pkg::K_SHR, '0, '0); mode = SC_IDLE; return; end
          push_tok(stt_pkg::K_GT, '0, '0);
        end
        default: ;
      endcase
      // idle scan: start of a new token
      mode = SC_IDLE;
      case (c)
        "#": mode = SC_COMMENT;
        "\"": mode = SC_QUOTE1;
        8'h0a: begin
          if (prev != stt_pkg::PREV_NONE && prev != stt_pkg::K_LBRACE &&
              prev != stt_pkg::K_RBRACE && prev != stt_pkg::K_SEMI)
            push_tok(stt_pkg::K_SEMI, '0, '0);
          bump_line();
        end
        "-": mode = SC_MINUS;
        "/": mode = SC_SLASH;
        "!": mode = SC_BANG;
        "=": mode = SC_EQ;
        "<": mode = SC_LT;
        ">": mode = SC_GT;
        "+": push_tok(stt_pkg::K_PLUS, '0, '0);
        "*": push_tok(stt_pkg::K_TIMES, '0, '0);
        "%": push_tok(stt_pkg::K_MODULO, '0, '0);
        "&": push_tok(stt_pkg::K_AND, '0, '0);
        "|": push_tok(stt_pkg::K_OR, '0, '0);
        "^": push_tok(stt_pkg::K_XOR, '0, '0);
        ";": push_tok(stt_pkg::K_SEMI, '0, '0);
        "(": push_tok(stt_pkg::K_LPAREN, '0, '0);
        ")": push_tok(stt_pkg::K_RPAREN, '0, '0);
        "{": push_tok(stt_pkg::K_LBRACE, '0, '0);
        "}": push_tok(stt_pkg::K_RBRACE, '0, '0);
        ",": push_tok(stt_pkg::K_COMMA, '0, '0);
        ":": push_tok(stt_pkg::K_COLON, '0, '0);
        " ", 8'h09: ;
        default: begin
          if (dig) begin
            mode = SC_NUMBER; neg = 1'b0; accum = 64'(c - "0");
          end else if (alp) begin
            mode = SC_WORD; wlen = 0; kw_live = 6'h3f;
            add_word_char(c);
          end else begin
            raise_error(c);
          end
        end
      endcase
    endfunction

    function void end_text();
      case (mode)
        SC_WORD: close_word();
        SC_NUMBER: close_number();
        SC_MINUS: push_tok(stt_pkg::K_MINUS, '0, '0);
        SC_SLASH: begin raise_error("/"); return; end
        SC_BANG: begin raise_error("!"); return; end
        SC_EQ: push_tok(stt_pkg::K_EQ, '0, '0);
        SC_LT: push_tok(stt_pkg::K_LT, '0, '0);
        SC_GT: push_tok(stt_pkg::K_GT, '0, '0);
        SC_QUOTE1, SC_STRING: begin raise_error(8'h00); return; end
        SC_QUOTE2: quote_pair();
        default: ;
      endcase
      push_tok(stt_pkg::K_EOF, '0, '0);
      clear();
    endfunction

    // an accepted input item
    function void note_input(logic k, logic [7:0] c);
      token_t e;
      int n;
      if (halted) return;
      made = 0;
      if (k) end_text();
      else feed(c);
      if (made > 0) begin
        n = expected_q.size() - 1;
        e = expected_q[n];
        e.fin = 1'b1;
        expected_q[n] = e;
      end
    endfunction

    // an accepted result against the oldest expectation
    function void check_result(logic [5:0] t, logic [23:0] ln, logic [63:0] v,
                               logic [7:0] b, logic f);
      token_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token kind=%0d line=%0d value=%0d byte=%0h last=%0b",
                   t, ln, $signed(v), b, f);
        return;
      end
      e = expected_q.pop_front();
      if (t !== e.tok || ln !== e.line || v !== e.value || b !== e.nbyte || f !== e.fin) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"token mismatch: exp kind=%0d line=%0d value=%0d byte=%0h last=%0b,",
                    " got kind=%0d line=%0d value=%0d byte=%0h last=%0b"},
                   e.tok, e.line, $signed(e.value), e.nbyte, e.fin,
                   t, ln, $signed(v), b, f);
      end
    endfunction
  endclass

  logic clk, rst;
  logic valid_in, ready_in, kind;
  logic [7:0] char_byte;
  logic valid_out, ready_out;
  logic [5:0] token_kind;
  logic [23:0] src_line;
  logic signed [63:0] number_value;
  logic [7:0] name_byte;
  logic last;

  token_scoreboard sb;
  int burst_left;
  int items_sent;
  int idle_cycles;
  int stall_phase;
  bit [7:0] text_q[$];

  source_text_tokenizer dut (
    .clk(clk), .rst(rst),
    .valid_in(valid_in), .ready_in(ready_in), .kind(kind), .char_byte(char_byte),
    .valid_out(valid_out), .ready_out(ready_out), .token_kind(token_kind),
    .src_line(src_line), .number_value(number_value), .name_byte(name_byte),
    .last(last)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // transfers on both sides, noted in acceptance order, plus the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (valid_in && ready_in) sb.note_input(kind, char_byte);
      if (valid_out && ready_out)
        sb.check_result(token_kind, src_line, number_value, name_byte, last);
      if ((valid_in && ready_in) || (valid_out && ready_out)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver stall pattern: free, light, heavy, in turn
  always @(negedge clk) begin
    stall_phase++;
    case ((stall_phase / 150) % 3)
      0: ready_out = 1'b1;
      1: ready_out = ($urandom_range(0, 3) != 0);
      default: ready_out = (stall_phase % 4 == 0) || ($urandom_range(0, 4) == 0);
    endcase
  end

  // one item, in bursts with random gaps
  task automatic send_item(logic k, logic [7:0] c);
    if (burst_left == 0) begin
      valid_in = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    kind = k;
    char_byte = c;
    valid_in = 1'b1;
    do @(posedge clk); while (!ready_in);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(bit with_end);
    foreach (text_q[i]) send_item(1'b0, text_q[i]);
    if (with_end) send_item(1'b1, 8'($urandom_range(0, 255)));
    text_q.delete();
  endtask

  // append one byte to the pending text
  task automatic add_byte(bit [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic bit [7:0] pick_byte(bit [7:0] avoid);
    bit [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  // one well-formed token or skipped piece with random content
  task automatic add_token();
    string ops[$] = '{"+", "-", "*", "//", "%", "&", "|", "^", "=", "==", "!=", "<",
                      "<=", "<<", ">", ">=", ">>", ";", "(", ")", "{", "}", ",", ":"};
    string kws[$] = '{"cst", "var", "if", "while", "else", "i64", "whil", "elsee", "i6"};
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    int sel, n;
    bit sep;
    sep = ($urandom_range(0, 2) != 0);
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      add_str(kws[$urandom_range(0, kws.size() - 1)]);
    end else if (sel < 35) begin
      add_byte(alnum[$urandom_range(0, 51)]);
      n = $urandom_range(0, 8);
      repeat (n) add_byte(alnum[$urandom_range(0, alnum.len() - 1)]);
    end else if (sel < 50) begin
      if ($urandom_range(0, 1)) add_byte("-");
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
      repeat (n) add_byte(8'(8'h30 + $urandom_range(0, 9)));
    end else if (sel < 72) begin
      add_str(ops[$urandom_range(0, ops.size() - 1)]);
    end else if (sel < 80) begin
      add_byte("\"");
      n = $urandom_range(0, 6);
      repeat (n) add_byte(pick_byte("\""));
      add_byte("\"");
      if (n == 0) sep = 1'b1;
    end else if (sel < 85) begin
      add_byte("#");
      repeat ($urandom_range(0, 6)) add_byte(pick_byte(8'h0a));
      add_byte(8'h0a);
    end else if (sel < 89) begin
      add_str("\"\"\"");
      repeat ($urandom_range(0, 6)) add_byte(pick_byte("\""));
      add_str("\"\"\"");
    end else begin
      add_byte(8'h0a);
    end
    if (sep) begin
      case ($urandom_range(0, 3))
        0: add_byte(8'h09);
        1: add_byte(8'h0a);
        default: add_byte(" ");
      endcase
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.mismatches = 0;
    rst = 1'b1;
    valid_in = 1'b0;
    kind = 1'b0;
    char_byte = '0;
    ready_out = 1'b1;
    burst_left = 0;
    items_sent = 0;
    idle_cycles = 0;
    stall_phase = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: keywords, every operator, number limits, comments, strings
    add_str("cst var if while else i64 x_9 whilex\n");
    add_str("+ - * // % & | ^ = == != < <= << > >= >> ;");
    add_str(" ( ) { } , :\n");
    send_text(1'b1);
    add_str("0 9223372036854775807 9223372036854775808 -9223372036854775808 ");
    add_str("-99999999999999999999 a-1\n{\n}\n# note\n\"\"\" blk\n\"x\" \"\"\" \"\" \"s\n");
    add_byte(8'hff);
    add_byte(8'h0d);
    add_str("\"\tx=1");
    send_text(1'b1);
    add_str("\"\"");
    send_text(1'b1);
    add_str("a<");
    send_text(1'b1);

    // hold off until the block has drained
    valid_in = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    // random well-formed texts
    while (items_sent < 460) begin
      repeat ($urandom_range(4, 20)) add_token();
      send_text(1'b1);
    end

    // one error case, then items that must be ignored
    case ($urandom_range(0, 8))
      0: add_str("x /a");
      1: add_str("x !a");
      2: add_str("x /");
      3: add_str("x !");
      4: add_str("a \"");
      5: add_str("a \"ab");
      6: begin add_str("a "); add_byte(8'h0d); end
      7: begin add_str("a "); add_byte(8'($urandom_range(128, 255))); end
      default: add_str("a _b");
    endcase
    send_text(1'b1);
    add_str("b+1\n");
    send_text(1'b1);
    valid_in = 1'b0;

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_back.sv
sv/source_text_tokenizer.sv
verif/tb_source_text_tokenizer.sv
